// ----- rtl/kpd_pkg.sv -----
// Shared types, constants and the key table for the keypad scanner.
`default_nettype none
package kpd_pkg;

  localparam int unsigned COL_W      = 4;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned DISP_W     = 16;
  localparam int unsigned SETTLE_W   = 8;
  localparam int unsigned DEBOUNCE_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DEBOUNCE_W;

  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROW_W-1:0]      row_drive_t;
  typedef logic [CODE_W-1:0]     code_t;
  typedef logic [DISP_W-1:0]     disp_t;
  typedef logic [SETTLE_W-1:0]   settle_t;
  typedef logic [DEBOUNCE_W-1:0] count_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_SETTLE   = 2'd0;
  localparam cfg_idx_t CFG_DEBOUNCE = 2'd1;

  // Reset values of the configuration registers.
  localparam settle_t SETTLE_RESET   = 8'd2;
  localparam count_t  DEBOUNCE_RESET = 20'd100000;

  // Special key codes.
  localparam code_t CLEAR_KEY   = 4'd13;
  localparam code_t DIGIT_LIMIT = 4'd10;

  // Key table indexed by {row, column}; row 0 is the first scanned row.
  localparam code_t KEY_TABLE [16] = '{
    4'd10, 4'd3,  4'd2, 4'd1,
    4'd11, 4'd6,  4'd5, 4'd4,
    4'd12, 4'd9,  4'd8, 4'd7,
    4'd13, 4'd14, 4'd0, 4'd15
  };

  typedef enum logic [1:0] {
    PH_SCAN    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  // Live configuration seen by the scan core.
  typedef struct packed {
    settle_t settle;
    count_t  debounce;
  } cfg_t;

  // One result item.
  typedef struct packed {
    row_drive_t row_drive;
    logic       key_valid;
    code_t      key_code;
    disp_t      display_value;
  } key_res_t;

endpackage
`default_nettype wire

// ----- rtl/kpd_if.sv -----
// Stream interfaces for column samples and key results.
`default_nettype none
interface kpd_col_if;
  import kpd_pkg::*;
  logic valid;
  logic ready;
  col_t column_levels;

  modport source (output valid, output column_levels, input ready);
  modport sink   (input valid, input column_levels, output ready);
endinterface

interface kpd_key_if;
  import kpd_pkg::*;
  logic       valid;
  logic       ready;
  row_drive_t row_drive;
  logic       key_valid;
  code_t      key_code;
  disp_t      display_value;

  modport source (output valid, output row_drive, output key_valid, output key_code,
                  output display_value, input ready);
  modport sink   (input valid, input row_drive, input key_valid, input key_code,
                  input display_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/keypad_scan_digit_entry_top.sv -----
// Top level: input register, configuration registers, scan core and result register.
// An accepted request is held in the input register, then moves to the result register.
// Throughput: one request per cycle unless stalled; the scan is one registered pass.
// While a result waits, one more request is held in the input register, then input stalls.
// Reset (synchronous, active low) restores settle 2, debounce 100000, scanning at row 0,
// counter and digit register zero; no clearing pass is needed.
`default_nettype none
module keypad_scan_digit_entry_top (
  input  wire                 clk,
  input  wire                 rst_n,
  kpd_col_if.sink             in_col,
  kpd_key_if.source           out_key,
  input  wire                 cfg_we,
  input  kpd_pkg::cfg_idx_t   cfg_index,
  input  kpd_pkg::cfg_data_t  cfg_wdata
);
  import kpd_pkg::*;

  logic     s1_valid_r;
  col_t     s1_cols_r;
  logic     out_valid_r;
  key_res_t out_res_r;
  key_res_t res;
  cfg_t     cfg_r;
  logic     advance;

  // A request moves into the core when the result register is free or being drained.
  assign advance      = s1_valid_r && (!out_valid_r || out_key.ready);
  assign in_col.ready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_col.ready) begin
      s1_valid_r <= in_col.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_col.valid && in_col.ready) begin
      s1_cols_r <= in_col.column_levels;
    end
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle   <= SETTLE_RESET;
      cfg_r.debounce <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE:   cfg_r.settle   <= cfg_wdata[SETTLE_W-1:0];
        CFG_DEBOUNCE: cfg_r.debounce <= cfg_wdata[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  kpd_scan_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .cols  (s1_cols_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_key.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_key.valid         = out_valid_r;
  assign out_key.row_drive     = out_res_r.row_drive;
  assign out_key.key_valid     = out_res_r.key_valid;
  assign out_key.key_code      = out_res_r.key_code;
  assign out_key.display_value = out_res_r.display_value;

  // A buffered request is never dropped while it waits for the result register.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_cols_r))
    else $error("buffered request lost");

  // Exactly one row is driven low on every delivered result.
  a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(~out_res_r.row_drive))
    else $error("row drive not one-cold");

  // A waiting result is not overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_key.ready |-> !advance)
    else $error("result register overwritten");

endmodule
`default_nettype wire

// ----- rtl/kpd_scan_core.sv -----
// Scan state machine, debounce counter and digit register; one step per fired request.
`default_nettype none
module kpd_scan_core (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               fire,
  input  kpd_pkg::col_t     cols,
  input  kpd_pkg::cfg_t     cfg,
  output kpd_pkg::key_res_t res
);
  import kpd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [1:0] row_r, row_nxt;
  logic [1:0] hit_r, hit_nxt;
  count_t     cnt_r, cnt_nxt;
  disp_t      digit_r, digit_nxt;

  count_t     cnt_inc;
  logic       low_any;
  logic [1:0] low_col;
  code_t      code;
  logic       report;
  code_t      res_code;

  // Lowest column that reads low.
  always_comb begin
    low_any = ~&cols;
    if (!cols[0]) begin
      low_col = 2'd0;
    end else if (!cols[1]) begin
      low_col = 2'd1;
    end else if (!cols[2]) begin
      low_col = 2'd2;
    end else begin
      low_col = 2'd3;
    end
  end

  assign cnt_inc = cnt_r + 20'd1;
  assign code    = KEY_TABLE[{row_r, hit_r}];

  // Next state for one tick.
  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    hit_nxt   = hit_r;
    cnt_nxt   = cnt_r;
    digit_nxt = digit_r;
    report    = 1'b0;
    case (phase_r)
      PH_SCAN: begin
        if (cnt_r < {{(DEBOUNCE_W-SETTLE_W){1'b0}}, cfg.settle}) begin
          cnt_nxt = cnt_inc;
        end else begin
          cnt_nxt = '0;
          if (low_any) begin
            hit_nxt   = low_col;
            phase_nxt = PH_PRESS;
          end else begin
            row_nxt = row_r + 2'd1;
          end
        end
      end
      PH_PRESS: begin
        if (cnt_r < cfg.debounce) begin
          cnt_nxt = cnt_inc;
        end else begin
          phase_nxt = PH_HOLD;
          cnt_nxt   = '0;
        end
      end
      PH_HOLD: begin
        if (cols[hit_r]) begin
          phase_nxt = PH_RELEASE;
          cnt_nxt   = '0;
        end
      end
      PH_RELEASE: begin
        if (cnt_r < cfg.debounce) begin
          cnt_nxt = cnt_inc;
        end else begin
          report    = 1'b1;
          phase_nxt = PH_SCAN;
          row_nxt   = 2'd0;
          cnt_nxt   = '0;
          if (code == CLEAR_KEY) begin
            digit_nxt = '0;
          end else if (code < DIGIT_LIMIT) begin
            digit_nxt = {digit_r[DISP_W-CODE_W-1:0], code};
          end
        end
      end
      default: begin
        phase_nxt = PH_SCAN;
      end
    endcase
  end

  // Result for this tick: the row driven now and the register after the update.
  assign res_code          = report ? code : '0;
  assign res.row_drive     = ~(4'b1000 >> row_r);
  assign res.key_valid     = report;
  assign res.key_code      = res_code;
  assign res.display_value = digit_nxt;

  // State registers advance only when a request is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SCAN;
      row_r   <= 2'd0;
      hit_r   <= 2'd0;
      cnt_r   <= '0;
      digit_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      hit_r   <= hit_nxt;
      cnt_r   <= cnt_nxt;
      digit_r <= digit_nxt;
    end
  end

  // A key is reported only from the release debounce phase.
  a_report_phase: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.key_valid |-> phase_r == PH_RELEASE)
    else $error("key reported outside release debounce");

  // After a report the scan restarts at the first row with a clear counter.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.key_valid |=> phase_r == PH_SCAN && row_r == 2'd0 && cnt_r == '0)
    else $error("scan did not restart after a report");

  // The digit register changes only on a report.
  a_digit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res.key_valid |=> $stable(digit_r))
    else $error("digit register changed without a report");

endmodule
`default_nettype wire
